// ----- hdl/crb_pkg.sv -----
// Shared types, command codes and helpers for the Catmull-Rom to Bezier stream block.
package crb_pkg;

   localparam int COORD_BITS = 32;
   localparam int D_W        = 35;  // Euclidean distance
   localparam int S_W        = 26;  // square root of distance, 8 extra fraction bits
   localparam int ACC_W      = 70;  // multiply accumulator, square root operand
   localparam int DEN_W      = 56;  // 3*s*(s+s')
   localparam int NUM_W      = 86;  // numerator magnitude shifted left by 16
   localparam int Q_W        = 41;  // quotient bits kept below the clamp
   localparam int CNT_W      = 7;
   localparam int MUL_STEPS  = 35;
   localparam int SQRT_STEPS = 35;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] vertex_x;
      logic signed [COORD_BITS-1:0] vertex_y;
      logic signed [COORD_BITS-1:0] vertex_z;
      logic [31:0]                  thickness;
      logic                         strand_end;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] point_z;
      logic [1:0]                   point_index;
      logic [31:0]                  width_start;
      logic [31:0]                  width_end;
      logic                         segment_done;
      logic                         run_done;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      logic [31:0]                  w;
   } vertex_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } coord3_type;

   // datapath operations
   localparam logic [3:0] OP_NOP       = 4'd0;
   localparam logic [3:0] OP_CAPTURE   = 4'd1;
   localparam logic [3:0] OP_LOAD      = 4'd2;
   localparam logic [3:0] OP_SQ        = 4'd3;
   localparam logic [3:0] OP_SQRT_D    = 4'd4;
   localparam logic [3:0] OP_SQRT_S    = 4'd5;
   localparam logic [3:0] OP_DEN       = 4'd6;
   localparam logic [3:0] OP_DEN_LATCH = 4'd7;
   localparam logic [3:0] OP_T1        = 4'd8;
   localparam logic [3:0] OP_T1_LATCH  = 4'd9;
   localparam logic [3:0] OP_T2        = 4'd10;
   localparam logic [3:0] OP_COMB      = 4'd11;
   localparam logic [3:0] OP_DIV       = 4'd12;
   localparam logic [3:0] OP_STORE     = 4'd13;
   localparam logic [3:0] OP_EMIT      = 4'd14;
   localparam logic [3:0] OP_SHIFT     = 4'd15;

   // segment windows
   localparam logic [1:0] SEG_FIRST = 2'd0;
   localparam logic [1:0] SEG_MID   = 2'd1;
   localparam logic [1:0] SEG_LAST  = 2'd2;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] j;     // distance pair
      logic [1:0] a;     // axis
      logic       k;     // inner point: 0 is B1, 1 is B2
      logic [1:0] p;     // emitted point
      logic [1:0] kind;  // segment window
      logic       last;  // final segment of this transfer
   } cmd_type;

   typedef struct packed {
      logic busy;
   } status_type;

   function automatic logic signed [COORD_BITS-1:0] axis_sel(vertex_type v, logic [1:0] a);
      logic signed [COORD_BITS-1:0] r;
      case (a)
         2'd0:    r = v.x;
         2'd1:    r = v.y;
         default: r = v.z;
      endcase
      return r;
   endfunction

   function automatic logic [COORD_BITS:0] mag33(logic signed [COORD_BITS:0] v);
      return v[COORD_BITS] ? (COORD_BITS+1)'(-v) : (COORD_BITS+1)'(v);
   endfunction

endpackage

// ----- hdl/crb_datapath.sv -----
// Datapath: vertex window, segment registers, shared multiplier, square root and divider.
module crb_datapath import crb_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_payload,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_payload
);

   localparam int CW_EFF = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam int SH     = 32 - CW_EFF;
   localparam logic signed [43:0] SAT_HI = (44'sd1 <<< (CW_EFF - 1)) - 44'sd1;
   localparam logic signed [43:0] SAT_LO = -SAT_HI - 44'sd1;
   localparam logic [ACC_W-1:0]   SQ_ONE = ACC_W'(1) << (2 * (SQRT_STEPS - 1));

   localparam logic [1:0] MODE_MUL = 2'd0;
   localparam logic [1:0] MODE_SQD = 2'd1;
   localparam logic [1:0] MODE_SQS = 2'd2;
   localparam logic [1:0] MODE_DIV = 2'd3;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       mode_ff, mode_in;

   vertex_type cur_ff, w0_ff, w1_ff, w2_ff;
   vertex_type p0_ff, p1_ff, p2_ff, p3_ff;
   logic [D_W-1:0]   d0_ff, d1_ff, d2_ff;
   logic [S_W-1:0]   s0_ff, s1_ff, s2_ff;
   logic [ACC_W-1:0] acc_ff, mcand_ff, t1_ff;
   logic [D_W-1:0]   mplier_ff;
   logic [ACC_W-1:0] sq_op_ff, sq_res_ff, sq_one_ff;
   logic [DEN_W-1:0] den_ff, rem_ff;
   logic [NUM_W-1:0] num_ff;
   logic [Q_W-1:0]   q_ff;
   logic             big_ff, neg_ff;
   coord3_type       b1_ff, b2_ff;
   rsp_type          rsp_ff;

   // operand selection
   vertex_type pa, pb, vb, vo, vu, cap;
   logic signed [COORD_BITS:0]   dif, eo, eu;
   logic signed [COORD_BITS-1:0] base;
   logic [COORD_BITS:0]          sq_x;
   logic [D_W-1:0]               dn, dsel;
   logic [S_W-1:0]               sn;
   logic [ACC_W-1:0]             num_mag, sq_t, sq_res_nx, sq_op_nx;
   logic                         neg1, neg2, neg_c, sq_ge, dv_ge;
   logic [DEN_W-1:0]             r2, rem_nx;
   logic [41:0]                  qv;
   logic signed [43:0]           qs, sum;
   logic signed [COORD_BITS-1:0] res_c;

   always_comb begin
      cap.x = (req_payload.vertex_x <<< SH) >>> SH;
      cap.y = (req_payload.vertex_y <<< SH) >>> SH;
      cap.z = (req_payload.vertex_z <<< SH) >>> SH;
      cap.w = req_payload.thickness;

      case (cmd.j)
         2'd0: begin pa = p0_ff; pb = p1_ff; dsel = d0_ff; end
         2'd1: begin pa = p1_ff; pb = p2_ff; dsel = d1_ff; end
         default: begin pa = p2_ff; pb = p3_ff; dsel = d2_ff; end
      endcase
      dif  = (COORD_BITS+1)'(axis_sel(pa, cmd.a)) - (COORD_BITS+1)'(axis_sel(pb, cmd.a));
      sq_x = mag33(dif);

      if (cmd.k) begin
         vb = p2_ff; vo = p1_ff; vu = p3_ff; dn = d2_ff; sn = s2_ff;
      end else begin
         vb = p1_ff; vo = p2_ff; vu = p0_ff; dn = d0_ff; sn = s0_ff;
      end
      base = axis_sel(vb, cmd.a);
      eo   = (COORD_BITS+1)'(axis_sel(vo, cmd.a)) - (COORD_BITS+1)'(base);
      eu   = (COORD_BITS+1)'(axis_sel(vu, cmd.a)) - (COORD_BITS+1)'(base);

      // signed combine of the two products, acc holds the second one
      neg1 = eo[COORD_BITS];
      neg2 = !eu[COORD_BITS];
      if (neg1 == neg2) begin
         num_mag = t1_ff + acc_ff;
         neg_c   = neg1;
      end else if (acc_ff <= t1_ff) begin
         num_mag = t1_ff - acc_ff;
         neg_c   = neg1;
      end else begin
         num_mag = acc_ff - t1_ff;
         neg_c   = neg2;
      end

      sq_t      = sq_res_ff + sq_one_ff;
      sq_ge     = sq_op_ff >= sq_t;
      sq_res_nx = sq_ge ? (sq_res_ff >> 1) + sq_one_ff : sq_res_ff >> 1;
      sq_op_nx  = sq_ge ? sq_op_ff - sq_t : sq_op_ff;

      r2     = {rem_ff[DEN_W-2:0], num_ff[NUM_W-1]};
      dv_ge  = r2 >= den_ff;
      rem_nx = dv_ge ? r2 - den_ff : r2;

      qv  = big_ff ? (42'd1 << Q_W) : 42'(q_ff);
      qs  = $signed({2'b00, qv});
      sum = neg_ff ? 44'(base) - qs : 44'(base) + qs;
      if (den_ff == '0)       res_c = base;
      else if (sum > SAT_HI)  res_c = SAT_HI[COORD_BITS-1:0];
      else if (sum < SAT_LO)  res_c = SAT_LO[COORD_BITS-1:0];
      else                    res_c = sum[COORD_BITS-1:0];
   end

   // iteration counter and unit mode
   always_comb begin
      cnt_in  = (cnt_ff != '0) ? cnt_ff - 1'b1 : cnt_ff;
      mode_in = mode_ff;
      case (cmd.op) inside
         OP_SQ, OP_DEN, OP_T1, OP_T2: begin
            cnt_in = CNT_W'(MUL_STEPS); mode_in = MODE_MUL;
         end
         OP_SQRT_D: begin cnt_in = CNT_W'(SQRT_STEPS); mode_in = MODE_SQD; end
         OP_SQRT_S: begin cnt_in = CNT_W'(SQRT_STEPS); mode_in = MODE_SQS; end
         OP_DIV:    begin cnt_in = CNT_W'(NUM_W); mode_in = MODE_DIV; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         mode_ff <= MODE_MUL;
      end else begin
         cnt_ff  <= cnt_in;
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: cur_ff <= cap;
         OP_LOAD: begin
            case (cmd.kind)
               SEG_FIRST: begin
                  p0_ff <= w0_ff; p1_ff <= w0_ff; p2_ff <= w1_ff; p3_ff <= w2_ff;
               end
               SEG_MID: begin
                  p0_ff <= w0_ff; p1_ff <= w1_ff; p2_ff <= w2_ff; p3_ff <= cur_ff;
               end
               default: begin
                  p0_ff <= w1_ff; p1_ff <= w2_ff; p2_ff <= cur_ff; p3_ff <= cur_ff;
               end
            endcase
         end
         OP_SQ: begin
            mcand_ff  <= ACC_W'(sq_x);
            mplier_ff <= D_W'(sq_x);
            if (cmd.a == 2'd0) acc_ff <= '0;
         end
         OP_SQRT_D: begin
            sq_op_ff <= acc_ff; sq_res_ff <= '0; sq_one_ff <= SQ_ONE;
         end
         OP_SQRT_S: begin
            sq_op_ff <= ACC_W'({dsel, 16'h0000}); sq_res_ff <= '0; sq_one_ff <= SQ_ONE;
         end
         OP_DEN: begin
            mcand_ff  <= ACC_W'(sn);
            mplier_ff <= D_W'(sn) + D_W'(s1_ff);
            acc_ff    <= '0;
         end
         OP_DEN_LATCH: den_ff <= DEN_W'(acc_ff + (acc_ff << 1));
         OP_T1: begin
            mcand_ff <= ACC_W'(dn); mplier_ff <= D_W'(mag33(eo)); acc_ff <= '0;
         end
         OP_T1_LATCH: t1_ff <= acc_ff;
         OP_T2: begin
            mcand_ff <= ACC_W'(d1_ff); mplier_ff <= D_W'(mag33(eu)); acc_ff <= '0;
         end
         OP_COMB: begin
            num_ff <= {num_mag, 16'h0000};
            neg_ff <= neg_c;
         end
         OP_DIV: begin
            rem_ff <= '0; q_ff <= '0; big_ff <= 1'b0;
         end
         OP_STORE: begin
            if (cmd.k) begin
               case (cmd.a)
                  2'd0:    b2_ff.x <= res_c;
                  2'd1:    b2_ff.y <= res_c;
                  default: b2_ff.z <= res_c;
               endcase
            end else begin
               case (cmd.a)
                  2'd0:    b1_ff.x <= res_c;
                  2'd1:    b1_ff.y <= res_c;
                  default: b1_ff.z <= res_c;
               endcase
            end
         end
         OP_EMIT: begin
            case (cmd.p)
               2'd0: begin
                  rsp_ff.point_x <= p1_ff.x; rsp_ff.point_y <= p1_ff.y;
                  rsp_ff.point_z <= p1_ff.z;
               end
               2'd1: begin
                  rsp_ff.point_x <= b1_ff.x; rsp_ff.point_y <= b1_ff.y;
                  rsp_ff.point_z <= b1_ff.z;
               end
               2'd2: begin
                  rsp_ff.point_x <= b2_ff.x; rsp_ff.point_y <= b2_ff.y;
                  rsp_ff.point_z <= b2_ff.z;
               end
               default: begin
                  rsp_ff.point_x <= p2_ff.x; rsp_ff.point_y <= p2_ff.y;
                  rsp_ff.point_z <= p2_ff.z;
               end
            endcase
            rsp_ff.point_index  <= cmd.p;
            rsp_ff.width_start  <= p0_ff.w;
            rsp_ff.width_end    <= p3_ff.w;
            rsp_ff.segment_done <= (cmd.p == 2'd3);
            rsp_ff.run_done     <= cmd.last && (cmd.p == 2'd3);
         end
         OP_SHIFT: begin
            w0_ff <= w1_ff; w1_ff <= w2_ff; w2_ff <= cur_ff;
         end
         default: begin
            if (cnt_ff != '0) begin
               case (mode_ff)
                  MODE_MUL: begin
                     if (mplier_ff[0]) acc_ff <= acc_ff + mcand_ff;
                     mcand_ff  <= mcand_ff << 1;
                     mplier_ff <= mplier_ff >> 1;
                  end
                  MODE_SQD, MODE_SQS: begin
                     sq_op_ff  <= sq_op_nx;
                     sq_res_ff <= sq_res_nx;
                     sq_one_ff <= sq_one_ff >> 2;
                     if (cnt_ff == CNT_W'(1)) begin
                        if (mode_ff == MODE_SQD) begin
                           case (cmd.j)
                              2'd0:    d0_ff <= sq_res_nx[D_W-1:0];
                              2'd1:    d1_ff <= sq_res_nx[D_W-1:0];
                              default: d2_ff <= sq_res_nx[D_W-1:0];
                           endcase
                        end else begin
                           case (cmd.j)
                              2'd0:    s0_ff <= sq_res_nx[S_W-1:0];
                              2'd1:    s1_ff <= sq_res_nx[S_W-1:0];
                              default: s2_ff <= sq_res_nx[S_W-1:0];
                           endcase
                        end
                     end
                  end
                  default: begin
                     rem_ff <= rem_nx;
                     num_ff <= num_ff << 1;
                     // quotient bits above the kept range only set the clamp flag
                     q_ff   <= {q_ff[Q_W-2:0], dv_ge && (cnt_ff <= CNT_W'(Q_W))};
                     if (dv_ge && (cnt_ff > CNT_W'(Q_W))) big_ff <= 1'b1;
                  end
               endcase
            end
         end
      endcase
   end

   assign status.busy = (cnt_ff != '0);
   assign rsp_payload = rsp_ff;

endmodule

// ----- hdl/crb_ctrl.sv -----
// Controller: sequences segments, micro-operations and result transfers.
module crb_ctrl import crb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_strand_end,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_LOAD   = 4'd1;
   localparam logic [3:0] ST_DSQ    = 4'd2;
   localparam logic [3:0] ST_DRT    = 4'd3;
   localparam logic [3:0] ST_SRT    = 4'd4;
   localparam logic [3:0] ST_DEN    = 4'd5;
   localparam logic [3:0] ST_DENL   = 4'd6;
   localparam logic [3:0] ST_T1     = 4'd7;
   localparam logic [3:0] ST_T1L    = 4'd8;
   localparam logic [3:0] ST_T2     = 4'd9;
   localparam logic [3:0] ST_COMB   = 4'd10;
   localparam logic [3:0] ST_DIV    = 4'd11;
   localparam logic [3:0] ST_STORE  = 4'd12;
   localparam logic [3:0] ST_EMIT   = 4'd13;
   localparam logic [3:0] ST_FINISH = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       issued_ff, issued_in;
   logic [1:0] j_ff, j_in, a_ff, a_in, p_ff, p_in, kind_ff, kind_in;
   logic       k_ff, k_in, last_pend_ff, last_pend_in, end_ff, end_in;
   logic [2:0] count_ff, count_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept, final_seg, can_load;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign final_seg = (kind_ff == SEG_LAST) || ((kind_ff == SEG_MID) && !last_pend_ff);
   assign can_load  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      j_in         = j_ff;
      a_in         = a_ff;
      k_in         = k_ff;
      p_in         = p_ff;
      kind_in      = kind_ff;
      last_pend_in = last_pend_ff;
      end_in       = end_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = OP_NOP;
      cmd.j        = j_ff;
      cmd.a        = a_ff;
      cmd.k        = k_ff;
      cmd.p        = p_ff;
      cmd.kind     = kind_ff;
      cmd.last     = final_seg;

      unique case (state_ff) inside
         ST_IDLE: begin
            if (accept) begin
               cmd.op       = OP_CAPTURE;
               end_in       = req_strand_end;
               last_pend_in = req_strand_end && (count_ff >= 3'd3);
               if (count_ff == 3'd3) begin
                  kind_in = SEG_FIRST; state_in = ST_LOAD;
               end else if (count_ff >= 3'd4) begin
                  kind_in = SEG_MID; state_in = ST_LOAD;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_LOAD: begin
            cmd.op = OP_LOAD; j_in = 2'd0; a_in = 2'd0; state_in = ST_DSQ;
         end
         ST_DSQ, ST_DRT, ST_SRT, ST_DEN, ST_T1, ST_T2, ST_DIV: begin
            if (!issued_ff) begin
               issued_in = 1'b1;
               case (state_ff)
                  ST_DSQ:  cmd.op = OP_SQ;
                  ST_DRT:  cmd.op = OP_SQRT_D;
                  ST_SRT:  cmd.op = OP_SQRT_S;
                  ST_DEN:  cmd.op = OP_DEN;
                  ST_T1:   cmd.op = OP_T1;
                  ST_T2:   cmd.op = OP_T2;
                  default: cmd.op = OP_DIV;
               endcase
            end else if (!status.busy) begin
               issued_in = 1'b0;
               case (state_ff)
                  ST_DSQ: begin
                     if (a_ff == 2'd2) begin
                        a_in = 2'd0; state_in = ST_DRT;
                     end else begin
                        a_in = a_ff + 2'd1;
                     end
                  end
                  ST_DRT: state_in = ST_SRT;
                  ST_SRT: begin
                     if (j_ff == 2'd2) begin
                        j_in = 2'd0; k_in = 1'b0; state_in = ST_DEN;
                     end else begin
                        j_in = j_ff + 2'd1; state_in = ST_DSQ;
                     end
                  end
                  ST_DEN:  state_in = ST_DENL;
                  ST_T1:   state_in = ST_T1L;
                  ST_T2:   state_in = ST_COMB;
                  default: state_in = ST_STORE;
               endcase
            end
         end
         ST_DENL: begin
            cmd.op = OP_DEN_LATCH; a_in = 2'd0; state_in = ST_T1;
         end
         ST_T1L: begin
            cmd.op = OP_T1_LATCH; state_in = ST_T2;
         end
         ST_COMB: begin
            cmd.op = OP_COMB; state_in = ST_DIV;
         end
         ST_STORE: begin
            cmd.op = OP_STORE;
            if (a_ff == 2'd2) begin
               a_in = 2'd0;
               if (k_ff) begin
                  p_in = 2'd0; state_in = ST_EMIT;
               end else begin
                  k_in = 1'b1; state_in = ST_DEN;
               end
            end else begin
               a_in = a_ff + 2'd1; state_in = ST_T1;
            end
         end
         ST_EMIT: begin
            if (can_load) begin
               cmd.op       = OP_EMIT;
               rsp_valid_in = 1'b1;
               p_in         = p_ff + 2'd1;
               if (p_ff == 2'd3) begin
                  if (kind_ff == SEG_FIRST) begin
                     kind_in = SEG_MID; state_in = ST_LOAD;
                  end else if ((kind_ff == SEG_MID) && last_pend_ff) begin
                     kind_in = SEG_LAST; state_in = ST_LOAD;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_FINISH: begin
            cmd.op   = OP_SHIFT;
            count_in = end_ff ? 3'd0 : ((count_ff >= 3'd4) ? 3'd4 : count_ff + 3'd1);
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         j_ff         <= 2'd0;
         a_ff         <= 2'd0;
         k_ff         <= 1'b0;
         p_ff         <= 2'd0;
         kind_ff      <= SEG_FIRST;
         last_pend_ff <= 1'b0;
         end_ff       <= 1'b0;
         count_ff     <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         j_ff         <= j_in;
         a_ff         <= a_in;
         k_ff         <= k_in;
         p_ff         <= p_in;
         kind_ff      <= kind_in;
         last_pend_ff <= last_pend_in;
         end_ff       <= end_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a running unit always belongs to an issued step
   a_busy_issued: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> issued_ff)
      else $error("datapath busy without an issued step");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("strand count beyond saturation");

   a_short_strand: assert property (@(posedge clock) disable iff (reset)
      (accept && count_ff < 3'd3) |=> state_ff == ST_FINISH)
      else $error("short strand started a segment");

   a_emit_whole: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT ##1 state_ff != ST_EMIT) |-> $past(p_ff) == 2'd3)
      else $error("segment left before its fourth point");

endmodule

// ----- hdl/catmull_rom_to_bezier_stream.sv -----
// Top level: centripetal Catmull-Rom to cubic Bezier conversion over a vertex stream.
// A vertex that starts no segment is captured and then shifted into the window; each
// segment is paced by the shared bit-serial multiplier, square root and 86-step divider.
// Throughput: one vertex at a time; up to three segments (12 points) per vertex.
// The last point of a segment can wait for its transfer while the next segment is computed.
// Reset clears the strand count, controller state and output valid; window is unset.
module catmull_rom_to_bezier_stream import crb_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   cmd_type    cmd;
   status_type status;

   crb_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_strand_end (req_payload.strand_end),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .status         (status),
      .cmd            (cmd)
   );

   crb_datapath #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- tb/catmull_rom_to_bezier_stream_tb.sv -----
// Testbench for the Catmull-Rom to Bezier stream block: directed and random strands checked against a predictor.
`timescale 1ns / 1ps

module catmull_rom_to_bezier_stream_tb;
   import crb_pkg::*;

   // Predicts the control points of each vertex and checks them in order.
   class bezier_board;
      rsp_type     points_due[$];
      vertex_type  win[3];
      int unsigned strand_len;
      int unsigned errors;

      function new();
         strand_len = 0;
         errors     = 0;
         for (int i = 0; i < 3; i++) win[i] = '0;
      endfunction

      function automatic longint axis(vertex_type v, int a);
         longint r;
         case (a)
            0:       r = v.x;
            1:       r = v.y;
            default: r = v.z;
         endcase
         return r;
      endfunction

      function automatic logic [63:0] mag64(longint v);
         return v < 0 ? 64'(-v) : 64'(v);
      endfunction

      // floor of the Euclidean distance
      function automatic logic [34:0] span(vertex_type a, vertex_type b);
         logic [69:0] acc;
         logic [34:0] r;
         logic [34:0] cand;
         logic [33:0] m;
         acc = '0;
         r   = '0;
         for (int i = 0; i < 3; i++) begin
            m   = 34'(mag64(axis(a, i) - axis(b, i)));
            acc = acc + 70'(m) * 70'(m);
         end
         for (int i = 34; i >= 0; i--) begin
            cand = r | (35'd1 << i);
            if (70'(cand) * 70'(cand) <= acc) r = cand;
         end
         return r;
      endfunction

      function automatic logic [63:0] root(logic [63:0] v);
         logic [63:0] r;
         logic [63:0] cand;
         r = '0;
         for (int i = 31; i >= 0; i--) begin
            cand = r | (64'd1 << i);
            if (cand * cand <= v) r = cand;
         end
         return r;
      endfunction

      function automatic logic signed [31:0] inner_point(longint base, longint oth, longint outer,
            logic [63:0] dn, logic [63:0] dm, logic [63:0] sn, logic [63:0] sm);
         logic [63:0]  den;
         logic [127:0] t1, t2, num, q;
         longint       eo, eu, res;
         bit           neg1, neg2, neg;
         den = 64'd3 * sn * (sn + sm);
         if (den == 0) return 32'(base);
         eo   = oth - base;
         eu   = outer - base;
         t1   = 128'(dn) * 128'(mag64(eo));
         t2   = 128'(dm) * 128'(mag64(eu));
         neg1 = eo < 0;
         neg2 = !(eu < 0);
         if (neg1 == neg2) begin
            num = t1 + t2;
            neg = neg1;
         end else if (t2 <= t1) begin
            num = t1 - t2;
            neg = neg1;
         end else begin
            num = t2 - t1;
            neg = neg2;
         end
         num = num << 16;
         q   = num / 128'(den);
         if (q >= (128'd1 << 41)) q = 128'd1 << 41;
         res = neg ? base - longint'(q) : base + longint'(q);
         if (res > 64'sd2147483647) res = 64'sd2147483647;
         if (res < -64'sd2147483648) res = -64'sd2147483648;
         return 32'(res);
      endfunction

      function automatic void add_segment(vertex_type p0, vertex_type p1,
            vertex_type p2, vertex_type p3);
         logic [63:0] d1, d2, d3, s1, s2, s3;
         longint      c [4][3];
         rsp_type     pt;
         d1 = 64'(span(p0, p1));
         d2 = 64'(span(p1, p2));
         d3 = 64'(span(p2, p3));
         s1 = root(d1 << 16);
         s2 = root(d2 << 16);
         s3 = root(d3 << 16);
         for (int a = 0; a < 3; a++) begin
            c[0][a] = axis(p1, a);
            c[1][a] = inner_point(axis(p1, a), axis(p2, a), axis(p0, a), d1, d2, s1, s2);
            c[2][a] = inner_point(axis(p2, a), axis(p1, a), axis(p3, a), d3, d2, s3, s2);
            c[3][a] = axis(p2, a);
         end
         for (int k = 0; k < 4; k++) begin
            pt.point_x      = 32'(c[k][0]);
            pt.point_y      = 32'(c[k][1]);
            pt.point_z      = 32'(c[k][2]);
            pt.point_index  = 2'(k);
            pt.width_start  = p0.w;
            pt.width_end    = p3.w;
            pt.segment_done = (k == 3);
            pt.run_done     = 1'b0;
            points_due.push_back(pt);
         end
      endfunction

      function automatic void note_vertex(req_type v);
         vertex_type cur;
         int unsigned n_prior;
         n_prior = points_due.size();
         cur.x  = v.vertex_x;
         cur.y  = v.vertex_y;
         cur.z  = v.vertex_z;
         cur.w  = v.thickness;
         if (strand_len == 3) add_segment(win[0], win[0], win[1], win[2]);
         if (strand_len >= 3) add_segment(win[0], win[1], win[2], cur);
         if (v.strand_end && strand_len >= 3) add_segment(win[1], win[2], cur, cur);
         if (points_due.size() > n_prior) points_due[points_due.size()-1].run_done = 1'b1;
         win[0] = win[1];
         win[1] = win[2];
         win[2] = cur;
         strand_len = v.strand_end ? 0 : (strand_len >= 4 ? 4 : strand_len + 1);
      endfunction

      function automatic void check_point(rsp_type got);
         rsp_type want;
         if (points_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected point %p", $time, got);
            return;
         end
         want = points_due.pop_front();
         if (got !== want) begin
            errors++;
            $display("%0t: point mismatch expected %p actual %p", $time, want, got);
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   bezier_board board = new();
   bit          hold_req = 0;
   bit          quiet = 0;
   int          vertex_count = 0;

   catmull_rom_to_bezier_stream u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // inputs change only at rising edges, so the falling edge sees settled handshakes
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_point(rsp_payload);
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (4000) @(posedge clock);
            hold_req = 0;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 31);
         end
      end
   end

   // called just after a rising edge; returns just after the edge of the transfer
   task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
         logic [31:0] w, bit last);
      req_type v;
      v.vertex_x   = x;
      v.vertex_y   = y;
      v.vertex_z   = z;
      v.thickness  = w;
      v.strand_end = last;
      while (!quiet && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= v;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      board.note_vertex(v);
      vertex_count++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.points_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_coord(int mode);
      logic [31:0] r;
      case (mode)
         0:       r = $urandom;
         1:       r = 32'($urandom_range(0, 32'h01ff_ffff)) - 32'h0100_0000;
         default: r = 32'($urandom_range(0, 3)) << 16;
      endcase
      return r;
   endfunction

   task automatic random_strand();
      int          len, mode;
      logic [31:0] x, y, z;
      len  = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 3) : $urandom_range(4, 9);
      mode = $urandom_range(0, 9);
      mode = mode < 2 ? 0 : (mode < 9 ? 1 : 2);
      x    = pick_coord(mode);
      y    = pick_coord(mode);
      z    = pick_coord(mode);
      for (int i = 0; i < len; i++) begin
         // occasional repeated vertex gives a zero distance
         if (i == 0 || $urandom_range(0, 99) >= 8) begin
            x = pick_coord(mode);
            y = pick_coord(mode);
            z = pick_coord(mode);
         end
         send_vertex(x, y, z, $urandom, i == len - 1);
      end
   endtask

   localparam logic [31:0] MAXV = 32'h7fff_ffff;
   localparam logic [31:0] MINV = 32'h8000_0000;

   initial begin
      int strand_no;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short strands produce nothing
      send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 1);
      send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0);
      send_vertex(32'h0004_0000, 32'h0000_0000, 32'h0000_0000, 32'h0002_0000, 1);
      send_vertex(MAXV, MINV, 32'h0, 32'hffff_ffff, 0);
      send_vertex(MINV, MAXV, 32'h0, 32'h0, 0);
      send_vertex(32'h0, 32'h0, MAXV, 32'h1, 1);
      // four vertices ending at the fourth: twelve points, full-scale coordinates
      send_vertex(MAXV, MAXV, MAXV, 32'hffff_ffff, 0);
      send_vertex(MINV, MINV, MINV, 32'h0, 0);
      send_vertex(MAXV, MINV, 32'h0, 32'h8000_0000, 0);
      send_vertex(32'h0, MAXV, MINV, 32'h7fff_ffff, 1);
      // repeated vertices: zero distances inside the strand
      send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0);
      send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 0);
      send_vertex(32'h0005_0000, 32'hfffb_0000, 32'h0000_8000, 32'h0003_0000, 0);
      send_vertex(32'h0005_0000, 32'hfffb_0000, 32'h0000_8000, 32'h0004_0000, 0);
      send_vertex(32'h000a_0000, 32'h0003_0000, 32'hffff_0000, 32'h0005_0000, 0);
      send_vertex(32'h000a_0001, 32'h0003_0000, 32'hffff_0000, 32'h0006_0000, 1);
      // longer strand with tiny steps
      send_vertex(32'h0, 32'h0, 32'h0, 32'h100, 0);
      send_vertex(32'h1, 32'h0, 32'h0, 32'h200, 0);
      send_vertex(32'h1, 32'h1, 32'h0, 32'h300, 0);
      send_vertex(32'h1, 32'h1, 32'h1, 32'h400, 0);
      send_vertex(32'hffff_ffff, 32'h1, 32'h1, 32'h500, 0);
      send_vertex(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h600, 1);
      drain();
      @(posedge clock);

      strand_no = 0;
      while (vertex_count < 405) begin
         if (strand_no == 10) hold_req = 1;
         if (strand_no == 20) begin
            drain();
            @(posedge clock);
         end
         quiet = (strand_no >= 30 && strand_no < 40);
         random_strand();
         strand_no++;
      end
      quiet = 0;
      drain();
      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.points_due.size() == 0)
         $display("catmull_rom_to_bezier_stream_tb: PASS");
      else
         $display("catmull_rom_to_bezier_stream_tb: FAIL");
      $finish;
   end

   initial begin
      #(64'd300_000_000);
      $display("catmull_rom_to_bezier_stream_tb: FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/crb_pkg.sv
hdl/crb_datapath.sv
hdl/crb_ctrl.sv
hdl/catmull_rom_to_bezier_stream.sv
tb/catmull_rom_to_bezier_stream_tb.sv
